### hw/rtl/bmdw_pkg.sv
// ----------------------------------------------------------------------------
// bmdw_pkg
// Shared types, register indexes, mangle codes and divide constants for the
// bit mangle dry/wet mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package bmdw_pkg;

   // Payload and register widths
   localparam int SAMPLE_W = 16;
   localparam int MODE_W   = 4;
   localparam int AMOUNT_W = 7;
   localparam int INDEX_W  = 2;
   localparam int WDATA_W  = 8;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [MODE_W-1:0]          mode_type;
   typedef logic [AMOUNT_W-1:0]        amount_type;
   typedef logic [INDEX_W-1:0]         index_type;
   typedef logic [WDATA_W-1:0]         wdata_type;

   // Register indexes
   localparam index_type REG_MANGLE_MODE = 2'd0;
   localparam index_type REG_WET_AMOUNT  = 2'd1;

   // Mangle codes
   localparam mode_type MODE_PASS      = 4'd0;
   localparam mode_type MODE_MASK_100F = 4'd1;
   localparam mode_type MODE_MASK_0FFF = 4'd2;
   localparam mode_type MODE_MASK_07FF = 4'd3;
   localparam mode_type MODE_SHL1      = 4'd4;
   localparam mode_type MODE_SHL2      = 4'd5;
   localparam mode_type MODE_SHL3      = 4'd6;
   localparam mode_type MODE_SHL5      = 4'd7;
   localparam mode_type MODE_SHL7      = 4'd8;
   localparam mode_type MODE_INVERT    = 4'd9;
   localparam mode_type MODE_MASK_F000 = 4'd10;
   localparam mode_type MODE_MASK_E7FF = 4'd11;
   localparam mode_type MODE_MASK_0087 = 4'd12;
   localparam mode_type MODE_MASK_F7FF = 4'd13;
   localparam mode_type MODE_MASK_9009 = 4'd14;
   localparam mode_type MODE_PASS_ALT  = 4'd15;

   // Mix scale and products
   localparam amount_type MIX_SCALE = 7'd127;
   localparam int PROD_W = 24;                 // |x*amt| < 2^22, signed
   typedef logic signed [PROD_W-1:0] prod_type;

   // Magnitude of the blended sum: at most 32768*127
   localparam int MAG_W = 22;
   typedef logic [MAG_W-1:0] mag_type;
   localparam mag_type MAG_MAX = 22'd4161536;

   // Divide by 127: q = (a * RECIP) >> RECIP_SHIFT, exact for a < 2^23
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP = 24'd8454661;
   localparam int QPROD_W = MAG_W + RECIP_W;
   typedef logic [QPROD_W-1:0] qprod_type;

   // Mangled copy of a sample
   function automatic sample_type mangle(input sample_type x, input mode_type mode);
      sample_type r;
      r = x;
      unique case (mode)
         MODE_MASK_100F: r = x & 16'h100F;
         MODE_MASK_0FFF: r = x & 16'h0FFF;
         MODE_MASK_07FF: r = x & 16'h07FF;
         MODE_SHL1:      r = x << 1;
         MODE_SHL2:      r = x << 2;
         MODE_SHL3:      r = x << 3;
         MODE_SHL5:      r = x << 5;
         MODE_SHL7:      r = x << 7;
         MODE_INVERT:    r = ~x;
         MODE_MASK_F000: r = x & 16'hF000;
         MODE_MASK_E7FF: r = x & 16'hE7FF;
         MODE_MASK_0087: r = x & 16'h0087;
         MODE_MASK_F7FF: r = x & 16'hF7FF;
         MODE_MASK_9009: r = x & 16'h9009;
         default:        r = x;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/bit_mangle_dry_wet_mixer.sv
// An accepted item reaches rsp_ after six register stages (mangle, two
// multipliers, add, magnitude, reciprocal multiply, sign restore); one
// item per cycle while rsp_stall is low.
// A bubble in the pipe is filled even while the output is stalled.
// Reset (synchronous, active high) empties the pipe and clears
// mangle_mode and wet_amount to 0.
// ----------------------------------------------------------------------------
// bit_mangle_dry_wet_mixer
// Builds a mangled copy of each signed 16-bit sample and blends it with the
// original, dividing by 127 with truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_mangle_dry_wet_mixer (
   input  wire                  clock,
   input  wire                  reset,
   // item input
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire bmdw_pkg::sample_type req_sample_in,
   input  wire                  req_block_last_in,
   // item output
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output bmdw_pkg::sample_type rsp_sample_out,
   output logic                 rsp_block_last_out,
   // register writes
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire bmdw_pkg::index_type csr_index,
   input  wire bmdw_pkg::wdata_type csr_wdata
);
   import bmdw_pkg::*;

   // Configuration registers
   mode_type   mode_ff;
   amount_type amount_ff;

   // Stage registers
   logic       s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   logic       s1_pass_ff, s2_pass_ff, s3_pass_ff, s4_pass_ff, s5_pass_ff;
   logic       s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff, s5_last_ff, s6_last_ff;
   sample_type s1_dry_ff, s2_dry_ff, s3_dry_ff, s4_dry_ff, s5_dry_ff;
   sample_type s1_wet_ff;
   amount_type s1_amt_ff;
   prod_type   s2_pw_ff, s2_pd_ff;
   prod_type   s3_sum_ff;
   logic       s4_neg_ff, s5_neg_ff;
   mag_type    s4_mag_ff;
   sample_type s5_quot_ff;
   sample_type s6_out_ff;

   // Next values
   logic       s1_pass_in;
   sample_type s1_wet_in;
   prod_type   s2_pw_in, s2_pd_in;
   prod_type   s3_sum_in;
   prod_type   s4_abs_in;
   mag_type    s4_mag_in;
   qprod_type  s5_qprod_in;
   sample_type s5_quot_in;
   sample_type s6_out_in;
   amount_type dry_amt;

   // Per-stage advance: a stage loads when empty or when its successor moves
   logic go1, go2, go3, go4, go5, go6;

   assign go6 = !s6_vld_ff || !rsp_stall;
   assign go5 = !s5_vld_ff || go6;
   assign go4 = !s4_vld_ff || go5;
   assign go3 = !s3_vld_ff || go4;
   assign go2 = !s2_vld_ff || go3;
   assign go1 = !s1_vld_ff || go2;

   assign req_stall = !go1;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PASS;
         amount_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MANGLE_MODE: mode_ff   <= csr_wdata[MODE_W-1:0];
            REG_WET_AMOUNT:  amount_ff <= csr_wdata[AMOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Datapath next values
   always_comb begin
      // stage 1: mangle
      s1_pass_in = (mode_ff == MODE_PASS) || (mode_ff == MODE_PASS_ALT);
      s1_wet_in  = mangle(req_sample_in, mode_ff);
      // stage 2: weight both paths
      dry_amt    = MIX_SCALE - s1_amt_ff;
      s2_pw_in   = prod_type'(s1_wet_ff) * prod_type'($signed({1'b0, s1_amt_ff}));
      s2_pd_in   = prod_type'(s1_dry_ff) * prod_type'($signed({1'b0, dry_amt}));
      // stage 3: blend
      s3_sum_in  = s2_pw_ff + s2_pd_ff;
      // stage 4: magnitude for truncating divide
      s4_abs_in  = s3_sum_ff[PROD_W-1] ? -s3_sum_ff : s3_sum_ff;
      s4_mag_in  = s4_abs_in[MAG_W-1:0];
      // stage 5: multiply by reciprocal of 127
      s5_qprod_in = qprod_type'(s4_mag_ff) * qprod_type'(RECIP);
      s5_quot_in  = s5_qprod_in[RECIP_SHIFT +: SAMPLE_W];
      // stage 6: restore sign or pass the dry sample
      if (s5_pass_ff) begin
         s6_out_in = s5_dry_ff;
      end else if (s5_neg_ff) begin
         s6_out_in = -s5_quot_ff;
      end else begin
         s6_out_in = s5_quot_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         if (go1) s1_vld_ff <= req_valid;
         if (go2) s2_vld_ff <= s1_vld_ff;
         if (go3) s3_vld_ff <= s2_vld_ff;
         if (go4) s4_vld_ff <= s3_vld_ff;
         if (go5) s5_vld_ff <= s4_vld_ff;
         if (go6) s6_vld_ff <= s5_vld_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (go1) begin
         s1_pass_ff <= s1_pass_in;
         s1_last_ff <= req_block_last_in;
         s1_dry_ff  <= req_sample_in;
         s1_wet_ff  <= s1_wet_in;
         s1_amt_ff  <= amount_ff;
      end
      if (go2) begin
         s2_pass_ff <= s1_pass_ff;
         s2_last_ff <= s1_last_ff;
         s2_dry_ff  <= s1_dry_ff;
         s2_pw_ff   <= s2_pw_in;
         s2_pd_ff   <= s2_pd_in;
      end
      if (go3) begin
         s3_pass_ff <= s2_pass_ff;
         s3_last_ff <= s2_last_ff;
         s3_dry_ff  <= s2_dry_ff;
         s3_sum_ff  <= s3_sum_in;
      end
      if (go4) begin
         s4_pass_ff <= s3_pass_ff;
         s4_last_ff <= s3_last_ff;
         s4_dry_ff  <= s3_dry_ff;
         s4_neg_ff  <= s3_sum_ff[PROD_W-1];
         s4_mag_ff  <= s4_mag_in;
      end
      if (go5) begin
         s5_pass_ff <= s4_pass_ff;
         s5_last_ff <= s4_last_ff;
         s5_dry_ff  <= s4_dry_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_quot_ff <= s5_quot_in;
      end
      if (go6) begin
         s6_last_ff <= s5_last_ff;
         s6_out_ff  <= s6_out_in;
      end
   end

   assign rsp_valid          = s6_vld_ff;
   assign rsp_sample_out     = s6_out_ff;
   assign rsp_block_last_out = s6_last_ff;

   // Checks
   // an accepted item always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_vld_ff)
      else $error("accepted item lost at stage 1");

   // input back-pressure only when the output side is blocked
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output back-pressure");

   // blended magnitude stays within 32768*127
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> (s4_mag_ff <= MAG_MAX))
      else $error("blend magnitude out of range");

   // a positive quotient never reaches 32768
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (s5_vld_ff && !s5_neg_ff && !s5_pass_ff) |-> !s5_quot_ff[SAMPLE_W-1])
      else $error("positive quotient overflow");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bit mangle dry/wet mixer. A scoreboard predicts
// each mixed sample from the current register values and checks results in
// order. Short directed pass, then random phases of items under random
// register settings, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------

module tb_top;
   import bmdw_pkg::*;

   localparam int ITEM_TARGET    = 1750;
   localparam int STALL_PCT      = 37;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 12;   // pipe is 6 deep
   localparam int QUIET_PHASE    = 3;

   // indexes past the two real registers; writes must change nothing
   localparam index_type REG_SPARE_2 = 2'd2;
   localparam index_type REG_SPARE_3 = 2'd3;

   typedef struct packed {
      sample_type sample;
      logic       last;
   } mix_result_type;

   // ------------------------------------------------------------------------
   // Scoreboard: shadow registers, mix predictor, queue of expected items
   // ------------------------------------------------------------------------
   class mix_scoreboard;
      mode_type       mode;
      amount_type     amount;
      int unsigned    errors;
      mix_result_type expected_q[$];

      function new();
         mode   = MODE_PASS;
         amount = '0;
         errors = 0;
      endfunction

      function void set_reg(index_type idx, wdata_type data);
         case (idx)
            REG_MANGLE_MODE: mode = data[MODE_W-1:0];
            REG_WET_AMOUNT:  amount = data[AMOUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // mangled copy blended with the dry sample, divide truncates to zero
      function sample_type mix_sample(sample_type s);
         logic [SAMPLE_W-1:0] raw;
         logic [SAMPLE_W-1:0] mangled;
         int dry;
         int wet;
         int num;
         raw     = s;
         mangled = raw;
         case (mode)
            MODE_MASK_100F: mangled = raw & 16'h100F;
            MODE_MASK_0FFF: mangled = raw & 16'h0FFF;
            MODE_MASK_07FF: mangled = raw & 16'h07FF;
            MODE_SHL1:      mangled = {raw[14:0], 1'b0};
            MODE_SHL2:      mangled = {raw[13:0], 2'b0};
            MODE_SHL3:      mangled = {raw[12:0], 3'b0};
            MODE_SHL5:      mangled = {raw[10:0], 5'b0};
            MODE_SHL7:      mangled = {raw[8:0], 7'b0};
            MODE_INVERT:    mangled = ~raw;
            MODE_MASK_F000: mangled = raw & 16'hF000;
            MODE_MASK_E7FF: mangled = raw & 16'hE7FF;
            MODE_MASK_0087: mangled = raw & 16'h0087;
            MODE_MASK_F7FF: mangled = raw & 16'hF7FF;
            MODE_MASK_9009: mangled = raw & 16'h9009;
            default:        mangled = raw;
         endcase
         // both pass codes ignore the wet amount
         if (mode == MODE_PASS || mode == MODE_PASS_ALT)
            return s;
         dry = s;
         wet = $signed(mangled);
         num = wet * int'(amount) + dry * (int'(MIX_SCALE) - int'(amount));
         return sample_type'(num / int'(MIX_SCALE));
      endfunction

      function void note_sample(sample_type s, logic last);
         mix_result_type r;
         r.sample = mix_sample(s);
         r.last   = last;
         expected_q.push_back(r);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      task check_result(sample_type s, logic last);
         mix_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("item with nothing expected: sample_out=%0d last=%0b", s, last));
            return;
         end
         want = expected_q.pop_front();
         if (s !== want.sample)
            report($sformatf("sample_out %0d, expected %0d", s, want.sample));
         if (last !== want.last)
            report($sformatf("block_last_out %0b, expected %0b", last, want.last));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Signals and block under test
   // ------------------------------------------------------------------------
   logic       clock;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   sample_type req_sample_in     = '0;
   logic       req_block_last_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   sample_type rsp_sample_out;
   logic       rsp_block_last_out;
   logic       csr_valid         = 1'b0;
   logic       csr_ready;
   index_type  csr_index         = '0;
   wdata_type  csr_wdata         = '0;

   bit          gap_enable   = 1'b1;
   int unsigned quiet_cycles = 0;
   mix_scoreboard sb = new();

   sample_type corner_samples [7] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
                                      16'sh0001, 16'shAAAA, 16'sh5555};

   bit_mangle_dry_wet_mixer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_in      (req_sample_in),
      .req_block_last_in  (req_block_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_block_last_out (rsp_block_last_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random output stall
   always @(posedge clock) begin
      rsp_stall <= gap_enable && ($urandom_range(99) < STALL_PCT);
   end

   // handshake monitor: feed and check the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_sample(req_sample_in, req_block_last_in);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_sample_out, rsp_block_last_out);
         if (csr_valid && csr_ready)
            sb.set_reg(csr_index, csr_wdata);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake in %0d cycles", $realtime, quiet_cycles);
            $display("bit_mangle_dry_wet_mixer test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_sample(sample_type s, logic last);
      while (gap_enable && ($urandom_range(99) < STALL_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_in     <= s;
      req_block_last_in <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait for every expected item
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // leaves csr_valid high; caller lowers it after the last write
   task automatic write_reg(index_type idx, wdata_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // unused upper data bits carry random junk
   task automatic apply_config(mode_type m, amount_type a);
      wdata_type w_mode;
      wdata_type w_amt;
      w_mode = wdata_type'($urandom);
      w_mode[MODE_W-1:0] = m;
      w_amt = wdata_type'($urandom);
      w_amt[AMOUNT_W-1:0] = a;
      drain();
      write_reg(REG_MANGLE_MODE, w_mode);
      write_reg(REG_WET_AMOUNT, w_amt);
      csr_valid <= 1'b0;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(3))
         0:       return corner_samples[$urandom_range(6)];
         1:       return sample_type'(int'($urandom_range(511)) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic amount_type pick_amount();
      case ($urandom_range(4))
         0:       return '0;
         1:       return MIX_SCALE;
         2:       return amount_type'(1);
         default: return amount_type'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      int phase_len;
      int random_sent;
      phase       = 0;
      random_sent = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: pass mode, dry
      for (int i = 0; i < 7; i++)
         send_sample(corner_samples[i], i[0]);

      // spare indexes are ignored
      drain();
      write_reg(REG_SPARE_2, 8'hFF);
      write_reg(REG_SPARE_3, 8'hA5);
      csr_valid <= 1'b0;
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7FFF, 1'b0);

      // every mangle code, fully wet
      drain();
      write_reg(REG_WET_AMOUNT, wdata_type'(MIX_SCALE));
      csr_valid <= 1'b0;
      for (int m = MODE_PASS; m <= MODE_PASS_ALT; m++) begin
         drain();
         write_reg(REG_MANGLE_MODE, wdata_type'(m));
         csr_valid <= 1'b0;
         send_sample(corner_samples[m % 7], m[0]);
      end

      // random phases, each under its own register setting
      while (random_sent < ITEM_TARGET) begin
         apply_config(mode_type'($urandom), pick_amount());
         gap_enable = (phase != QUIET_PHASE);
         phase_len  = (phase == QUIET_PHASE) ? 300 : $urandom_range(40, 140);
         repeat (phase_len) begin
            send_sample(pick_sample(), logic'($urandom_range(1)));
            random_sent++;
         end
         phase++;
      end
      gap_enable = 1'b1;

      // wind down
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected items never came out", sb.pending()));

      if (sb.errors == 0)
         $display("bit_mangle_dry_wet_mixer test passed");
      else
         $display("bit_mangle_dry_wet_mixer test failed");
      $finish;
   end

endmodule
